[rtl/plc_pkg.sv]
// Shared types, sizes and codes for the positional list store.
package plc_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_LOCATE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_RANGE   = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// Command broadcast to every cell of the row
	typedef struct packed {
		logic               insert;
		logic               remove;
		logic [IDX_W-1:0]   pidx;
		logic signed [31:0] value;
	} cell_ctl_t;

endpackage

[rtl/positional_list_store.sv]
// Top level: request checks, the row of list cells and the result register.
// An accepted request is held in the update register while the row shifts; done and the
// result are then loaded into their registers together.
// No new request is taken while busy; busy covers the cycle in which the cell row
// shifts and the count updates, since the next check needs the new count.
// Reset clears the count and control flags; cell contents stay unknown until
// written, and only positions below the count are ever read.
// The receiver cannot stall: each result is shown for one cycle with done.
module positional_list_store (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [4:0]         position,
	input  logic signed [31:0] item_value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] read_value,
	output logic [4:0]         found_position,
	output logic [4:0]         list_length
);
	import plc_pkg::*;

	logic               valid_s1;
	logic               ok_s1;
	op_t                op_s1;
	status_t            st_s1;
	logic [IDX_W-1:0]   pidx_s1;
	logic signed [31:0] val_s1;

	logic [CNT_W-1:0]   count_q;
	logic               done_q;
	status_t            status_q;
	logic signed [31:0] read_q;
	logic [4:0]         found_q;
	logic [4:0]         length_q;

	logic               accept;
	logic [CMP_W-1:0]   pos_w;
	logic [CMP_W-1:0]   cnt_w;
	logic [CMP_W-1:0]   pos_m1;
	logic               chk_ok;
	status_t            chk_st;

	cell_ctl_t          ctl;
	logic signed [31:0] cell_entry [CAPACITY];
	logic               cell_match [CAPACITY];
	logic [CMP_W-1:0]   found_w;
	logic signed [31:0] sel_entry;
	logic [CNT_W-1:0]   count_next;

	assign accept = start && !busy;
	assign busy   = valid_s1;

	// Check the position against the count at accept
	assign pos_w  = CMP_W'(position);
	assign cnt_w  = CMP_W'(count_q);
	assign pos_m1 = pos_w - CMP_W'(1);

	always_comb begin
		chk_ok = 1'b0;
		chk_st = ST_DONE;
		case (op_t'(op))
			OP_INSERT: begin
				if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
					chk_st = ST_RANGE;
				end else if (cnt_w >= CMP_W'(CAPACITY)) begin
					chk_st = ST_FULL;
				end else begin
					chk_ok = 1'b1;
				end
			end
			OP_DELETE, OP_GET: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					chk_st = ST_RANGE;
				end else begin
					chk_ok = 1'b1;
				end
			end
			OP_LOCATE: begin
				chk_ok = 1'b1;
			end
			default: begin
				chk_ok = 1'b0;
			end
		endcase
	end

	// Hold the accepted request for the update cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1   <= chk_ok;
			op_s1   <= op_t'(op);
			st_s1   <= chk_st;
			pidx_s1 <= pos_m1[IDX_W-1:0];
			val_s1  <= item_value;
		end
	end

	// Broadcast the command to the row
	always_comb begin
		ctl.insert = valid_s1 && ok_s1 && (op_s1 == OP_INSERT);
		ctl.remove = valid_s1 && ok_s1 && (op_s1 == OP_DELETE);
		ctl.pidx   = pidx_s1;
		ctl.value  = val_s1;
	end

	// Row of cells, each wired to its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] lower_in;
		logic signed [31:0] upper_in;
		if (i == 0) begin : g_first
			assign lower_in = '0;
		end else begin : g_mid_lo
			assign lower_in = cell_entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper_in = cell_entry[i];
		end else begin : g_mid_hi
			assign upper_in = cell_entry[i+1];
		end
		plc_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.idx   (IDX_W'(i)),
			.lower (lower_in),
			.upper (upper_in),
			.entry (cell_entry[i]),
			.match (cell_match[i])
		);
	end

	// Pick the first held entry that matches
	always_comb begin
		found_w = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i] && (CNT_W'(i) < count_q)) begin
				found_w = CMP_W'(i + 1);
			end
		end
	end

	assign sel_entry = (ok_s1 && (op_s1 == OP_DELETE || op_s1 == OP_GET))
		? cell_entry[pidx_s1] : '0;

	always_comb begin
		count_next = count_q;
		if (ctl.insert) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctl.remove) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// Advance the count and the done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= valid_s1;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_q   <= sel_entry;
			length_q <= 5'(count_next);
			if (op_s1 == OP_LOCATE) begin
				status_q <= (found_w == '0) ? ST_MISSING : ST_DONE;
				found_q  <= found_w[4:0];
			end else begin
				status_q <= st_s1;
				found_q  <= '0;
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign read_value     = read_q;
	assign found_position = found_q;
	assign list_length    = length_q;

	a_update_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("update cycle not followed by done");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("count above capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !accept)
		else $error("request accepted during update");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_FULL) |-> CMP_W'(count_q) == CMP_W'(CAPACITY))
		else $error("full reported with room left");

endmodule

[rtl/plc_cell.sv]
// One list slot: holds an entry and shifts it to or from its neighbors.
module plc_cell (
	input  logic                      clk,
	input  plc_pkg::cell_ctl_t        ctl,
	input  logic [plc_pkg::IDX_W-1:0] idx,
	input  logic signed [31:0]        lower,
	input  logic signed [31:0]        upper,
	output logic signed [31:0]        entry,
	output logic                      match
);
	import plc_pkg::*;

	logic signed [31:0] entry_q;

	// Take the new value, shift up from below on insert, shift down on delete
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (idx > ctl.pidx) begin
				entry_q <= lower;
			end else if (idx == ctl.pidx) begin
				entry_q <= ctl.value;
			end
		end else if (ctl.remove) begin
			if (idx >= ctl.pidx) begin
				entry_q <= upper;
			end
		end
	end

	assign entry = entry_q;
	assign match = (entry_q == ctl.value);

endmodule

[verif/positional_list_store_test.sv]
// Self-checking testbench for the positional list store: scoreboard class and top module.
`timescale 1ns / 1ps

import plc_pkg::*;

typedef struct {
	status_t            status;
	logic signed [31:0] read_value;
	logic [4:0]         found_position;
	logic [4:0]         list_length;
} list_reply_t;

// Predict list replies for accepted requests and check them in order
class list_scoreboard;
	logic signed [31:0] cells [CAPACITY];
	int unsigned        length;
	list_reply_t        replies [$];
	int                 errors;
	int                 requests;
	int                 checked;
	int                 range_hits;
	int                 full_hits;
	int                 miss_hits;
	int                 peak_length;

	function new();
		foreach (cells[i]) cells[i] = '0;
		length = 0;
		errors = 0;
		requests = 0;
		checked = 0;
		range_hits = 0;
		full_hits = 0;
		miss_hits = 0;
		peak_length = 0;
	endfunction

	// Apply one request to the shadow list and queue its reply
	function void note_request(op_t req_op, logic [4:0] pos, logic signed [31:0] val);
		list_reply_t r;
		int          j;
		r.status = ST_DONE;
		r.read_value = '0;
		r.found_position = '0;
		case (req_op)
			OP_INSERT: begin
				if (pos < 1 || pos > length + 1) begin
					r.status = ST_RANGE;
				end else if (length >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (j = length; j >= pos; j--)
						cells[j] = cells[j-1];
					cells[pos-1] = val;
					length++;
				end
			end
			OP_DELETE: begin
				if (pos < 1 || pos > length) begin
					r.status = ST_RANGE;
				end else begin
					r.read_value = cells[pos-1];
					for (j = pos; j < length; j++)
						cells[j-1] = cells[j];
					length--;
				end
			end
			OP_GET: begin
				if (pos < 1 || pos > length)
					r.status = ST_RANGE;
				else
					r.read_value = cells[pos-1];
			end
			default: begin
				r.status = ST_MISSING;
				for (j = 0; j < length; j++) begin
					if (cells[j] == val) begin
						r.found_position = 5'(j + 1);
						r.status = ST_DONE;
						break;
					end
				end
			end
		endcase
		r.list_length = 5'(length);
		if (r.status == ST_RANGE) range_hits++;
		if (r.status == ST_FULL) full_hits++;
		if (r.status == ST_MISSING) miss_hits++;
		if (length > peak_length) peak_length = length;
		requests++;
		replies.push_back(r);
	endfunction

	function void compare_field(string name, logic signed [31:0] exp, logic signed [31:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			errors++;
		end
	endfunction

	// Check one reply against the oldest prediction
	function void check_result(logic [1:0] st, logic signed [31:0] rd, logic [4:0] fp,
			logic [4:0] len);
		list_reply_t r;
		if (replies.size() == 0) begin
			$error("reply with no request outstanding: status %0d", st);
			errors++;
			return;
		end
		r = replies.pop_front();
		compare_field("status", r.status, st);
		compare_field("read_value", r.read_value, rd);
		compare_field("found_position", r.found_position, fp);
		compare_field("list_length", r.list_length, len);
		checked++;
	endfunction
endclass

module positional_list_store_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 200;
	localparam int MAX_GAP = 60;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         op;
	logic [4:0]         position;
	logic signed [31:0] item_value;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] read_value;
	logic [4:0]         found_position;
	logic [4:0]         list_length;

	list_scoreboard sb = new();
	int             idle_pct = 0;

	positional_list_store dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.position       (position),
		.item_value     (item_value),
		.done           (done),
		.status         (status),
		.read_value     (read_value),
		.found_position (found_position),
		.list_length    (list_length)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check every strobed reply
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, read_value, found_position, list_length);
	end

	// End the run when nothing transfers for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// Hold start low for a random stretch, drawn from the current idle rate
	task automatic sender_gap();
		int n;
		n = 0;
		while (n < MAX_GAP && idle_pct > 0 && $urandom_range(99) < idle_pct)
			n++;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Present one request and hold it until the transfer
	task automatic send_request(op_t req_op, logic [4:0] pos, logic signed [31:0] val);
		start <= 1'b1;
		op <= req_op;
		position <= pos;
		item_value <= val;
		do @(posedge clk); while (busy);
		sb.note_request(req_op, pos, val);
		sender_gap();
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return -32'sd1;
			3: return 32'($urandom_range(7));
			default: return $urandom;
		endcase
	endfunction

	// Build one random request that mostly lands on valid positions
	task automatic random_request(int grow_pct);
		op_t                req_op;
		logic [4:0]         pos;
		logic signed [31:0] val;
		int                 n;
		int                 r;
		n = sb.length;
		r = $urandom_range(99);
		if (r < 50)
			req_op = ($urandom_range(99) < grow_pct) ? OP_INSERT : OP_DELETE;
		else if (r < 72)
			req_op = OP_GET;
		else
			req_op = OP_LOCATE;
		if ($urandom_range(9) == 0 || req_op == OP_LOCATE)
			pos = 5'($urandom_range(31));
		else if (req_op == OP_INSERT)
			pos = 5'($urandom_range(n + 1, 1));
		else if (n == 0)
			pos = 5'($urandom_range(31));
		else
			pos = 5'($urandom_range(n, 1));
		if (req_op == OP_LOCATE && n > 0 && $urandom_range(1) == 0)
			val = sb.cells[$urandom_range(n - 1)];
		else
			val = pick_value();
		send_request(req_op, pos, val);
	endtask

	initial begin
		int pcts [4];
		int grow;
		int i;
		int ph;
		pcts = '{0, 87, 27, 0};
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_INSERT;
		position <= '0;
		item_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, range checks, both ends, full list
		send_request(OP_GET, 5'd1, 32'sd0);
		send_request(OP_DELETE, 5'd0, 32'sd0);
		send_request(OP_LOCATE, 5'd7, 32'sd0);
		send_request(OP_INSERT, 5'd0, 32'sd5);
		send_request(OP_INSERT, 5'd2, 32'sd5);
		send_request(OP_INSERT, 5'd1, 32'sh7fffffff);
		send_request(OP_INSERT, 5'd1, 32'sh80000000);
		send_request(OP_INSERT, 5'd3, -32'sd1);
		send_request(OP_INSERT, 5'd2, 32'sd0);
		while (sb.length < CAPACITY)
			send_request(OP_INSERT, 5'($urandom_range(sb.length + 1, 1)), $urandom);
		send_request(OP_INSERT, 5'd5, 32'sd9);
		send_request(OP_INSERT, 5'd17, 32'sd9);
		send_request(OP_INSERT, 5'd18, 32'sd9);
		send_request(OP_INSERT, 5'd31, 32'sd9);
		send_request(OP_GET, 5'd16, 32'sd0);
		send_request(OP_GET, 5'd17, 32'sd0);
		send_request(OP_GET, 5'd0, 32'sd0);
		send_request(OP_LOCATE, 5'd31, 32'sh80000000);
		send_request(OP_LOCATE, 5'd0, 32'sh13572468);
		send_request(OP_DELETE, 5'd16, 32'sd0);
		send_request(OP_DELETE, 5'd1, 32'sd0);
		send_request(OP_DELETE, 5'd31, 32'sd0);

		// Random: idle phases, list growth bias moved every few dozen items
		grow = 50;
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = pcts[ph];
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 40 == 0) begin
					case ($urandom_range(2))
						0: grow = 15;
						1: grow = 50;
						default: grow = 85;
					endcase
				end
				random_request(grow);
			end
		end
		start <= 1'b0;

		// Drain outstanding replies, then allow for the pipeline
		while (sb.replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d requests, %0d replies checked, list length peaked at %0d",
			sb.requests, sb.checked, sb.peak_length);
		$display("rejections seen: %0d out of range, %0d list full, %0d locate misses",
			sb.range_hits, sb.full_hits, sb.miss_hits);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[positional_list_store.f]
rtl/plc_pkg.sv
rtl/plc_cell.sv
rtl/positional_list_store.sv
verif/positional_list_store_test.sv
